// ===== hdl/stt_pkg.sv =====
// package for the source text tokenizer: item codes, scan modes, burst record
// no dependencies
package stt_pkg;

  localparam int MaxRes = 6;
  localparam int CntW = 3;

  typedef enum logic [1:0] {
    K_BYTE = 2'd0, K_END = 2'd1, K_ERR = 2'd2, K_DONE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    C_SYM = 4'd0, C_SYMEQ = 4'd1, C_POW = 4'd2, C_INT = 4'd3, C_BIN = 4'd4,
    C_HEX = 4'd5, C_FLOAT = 4'd6, C_IDENT = 4'd7, C_CHAR = 4'd8, C_STRING = 4'd9
  } cls_t;

  typedef enum logic [4:0] {
    M_SKIP, M_LINE, M_BLK0, M_BLK1, M_BLK2, M_ERRSKIP, M_OPEQ, M_STAR,
    M_ZERO, M_RUN, M_QUOTE, M_QESC, M_QHEX
  } mode_t;

  typedef enum logic [1:0] {
    H_NONE = 2'd0, H_SLASH = 2'd1, H_SLASHHASH = 2'd2
  } held_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
    logic [3:0] cls;
    logic       ok;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [CntW-1:0]   n;
  } burst_t;

  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_dig(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

endpackage

// ===== hdl/stt_if.sv =====
// valid/ready channel interface for the tokenizer
// no dependencies
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, text_byte, input ready);
  modport sink (input valid, text_byte, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] byte_value;
  logic [3:0] token_class;
  logic       text_ok;
  logic       last_of_run;
  modport source (output valid, item_kind, byte_value, token_class, text_ok, last_of_run,
                  input ready);
  modport sink (input valid, item_kind, byte_value, token_class, text_ok, last_of_run,
                output ready);
endinterface

// ===== hdl/stt_front.sv =====
// front end: scan state machine, turns one byte into a burst of results
// depends on stt_pkg
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       push,
  output burst_t     burst,
  input  logic       q_full
);

  mode_t      mode, mode_next;
  logic [3:0] pend, pend_next;
  held_t      held, held_next;
  logic [7:0] qch, qch_next;
  logic [1:0] qlen, qlen_next;
  logic       err, err_next;
  burst_t     bn;

  assign in_ready = !q_full;
  assign push = in_valid && in_ready && bn.n != '0;
  assign burst = bn;

  always_comb begin
    logic [7:0] b;
    logic       rescan;
    logic       rok;
    b = in_byte;
    rescan = 1'b0;
    rok = 1'b0;
    mode_next = mode; pend_next = pend; held_next = held; qch_next = qch;
    qlen_next = qlen; err_next = err;
    bn = '0;

    if (mode == M_SKIP && held == H_SLASH) begin
      held_next = H_NONE;
      if (b == "/") mode_next = M_LINE;
      else if (b == "#") held_next = H_SLASHHASH;
      else if (b == "=") begin
        bn.r[0] = '{K_BYTE, "/", 4'd0, 1'b0};
        bn.r[1] = '{K_BYTE, "=", 4'd0, 1'b0};
        bn.r[2] = '{K_END, 8'd0, C_SYMEQ, 1'b0};
        bn.n = 3'd3;
      end else begin
        bn.r[0] = '{K_BYTE, "/", 4'd0, 1'b0};
        bn.r[1] = '{K_END, 8'd0, C_SYM, 1'b0};
        bn.n = 3'd2; rescan = 1'b1;
      end
    end else if (mode == M_SKIP && held != H_NONE) begin
      held_next = H_NONE;
      if (b == "{") mode_next = M_BLK0;
      else begin
        bn.r[0] = '{K_BYTE, "/", 4'd0, 1'b0};
        bn.r[1] = '{K_END, 8'd0, C_SYM, 1'b0};
        bn.r[2] = '{K_BYTE, "#", 4'd0, 1'b0};
        bn.r[3] = '{K_END, 8'd0, C_SYM, 1'b0};
        bn.n = 3'd4; rescan = 1'b1;
      end
    end else begin
      unique case (mode)
        M_SKIP: rescan = 1'b1;
        M_LINE, M_ERRSKIP: begin
          if (b == 8'd0) begin
            bn.r[0] = '{K_DONE, 8'd0, 4'd0, !err}; bn.n = 3'd1;
            mode_next = M_SKIP; pend_next = '0; held_next = H_NONE;
            qch_next = '0; qlen_next = '0; err_next = 1'b0;
          end else if (b == 8'h0a) mode_next = M_SKIP;
        end
        M_BLK0, M_BLK1, M_BLK2: begin
          if (b == 8'd0) begin
            bn.r[0] = '{K_DONE, 8'd0, 4'd0, !err}; bn.n = 3'd1;
            mode_next = M_SKIP; pend_next = '0; held_next = H_NONE;
            qch_next = '0; qlen_next = '0; err_next = 1'b0;
          end else if (b == "}") mode_next = M_BLK1;
          else if (mode == M_BLK1 && b == "#") mode_next = M_BLK2;
          else if (mode == M_BLK2 && b == "/") mode_next = M_SKIP;
          else mode_next = M_BLK0;
        end
        M_OPEQ: begin
          if (b == "=") begin
            bn.r[0] = '{K_BYTE, b, 4'd0, 1'b0};
            bn.r[1] = '{K_END, 8'd0, C_SYMEQ, 1'b0};
            bn.n = 3'd2; mode_next = M_SKIP;
          end else begin
            bn.r[0] = '{K_END, 8'd0, C_SYM, 1'b0}; bn.n = 3'd1; rescan = 1'b1;
          end
        end
        M_STAR: begin
          if (b == "*" || b == "=") begin
            bn.r[0] = '{K_BYTE, b, 4'd0, 1'b0};
            bn.r[1] = '{K_END, 8'd0, (b == "*") ? C_POW : C_SYMEQ, 1'b0};
            bn.n = 3'd2; mode_next = M_SKIP;
          end else begin
            bn.r[0] = '{K_END, 8'd0, C_SYM, 1'b0}; bn.n = 3'd1; rescan = 1'b1;
          end
        end
        M_ZERO: begin
          if (b == "b") begin pend_next = C_BIN; mode_next = M_RUN; end
          else if (b == "x") begin pend_next = C_HEX; mode_next = M_RUN; end
          else begin
            bn.r[0] = '{K_BYTE, "0", 4'd0, 1'b0};
            bn.r[1] = '{K_END, 8'd0, C_INT, 1'b0};
            bn.n = 3'd2; rescan = 1'b1;
          end
        end
        M_RUN: begin
          priority case (pend)
            C_INT, C_FLOAT: rok = is_dig(b);
            C_BIN: rok = (b == "0" || b == "1");
            C_HEX: rok = is_hex(b);
            C_IDENT: rok = is_alpha(b) || is_dig(b);
            default: rok = 1'b0;
          endcase
          if (pend == C_INT && b == ".") begin
            bn.r[0] = '{K_BYTE, b, 4'd0, 1'b0}; bn.n = 3'd1; pend_next = C_FLOAT;
          end else if (rok) begin
            bn.r[0] = '{K_BYTE, b, 4'd0, 1'b0}; bn.n = 3'd1;
          end else begin
            bn.r[0] = '{K_END, 8'd0, pend, 1'b0}; bn.n = 3'd1; rescan = 1'b1;
          end
        end
        M_QUOTE, M_QHEX: begin
          if (mode == M_QHEX && is_hex(b)) begin
          end else begin
            mode_next = M_QUOTE;
            if (b == 8'd0) begin
              bn.r[0] = '{K_END, 8'd0,
                          (qch == 8'h27 && qlen <= 2'd1) ? C_CHAR : C_STRING, 1'b0};
              bn.r[1] = '{K_DONE, 8'd0, 4'd0, !err}; bn.n = 3'd2;
              mode_next = M_SKIP; pend_next = '0; held_next = H_NONE;
              qch_next = '0; qlen_next = '0; err_next = 1'b0;
            end else if (b == qch) begin
              bn.r[0] = '{K_END, 8'd0,
                          (qch == 8'h27 && qlen <= 2'd1) ? C_CHAR : C_STRING, 1'b0};
              bn.n = 3'd1; mode_next = M_SKIP;
            end else if (b == 8'h5c) mode_next = M_QESC;
            else begin
              bn.r[0] = '{K_BYTE, b, 4'd0, 1'b0}; bn.n = 3'd1;
              if (qlen < 2'd2) qlen_next = qlen + 2'd1;
            end
          end
        end
        M_QESC: begin
          if (b == "x") mode_next = M_QHEX;
          else if (is_dig(b)) mode_next = M_QUOTE;
          else if (b == "n" || b == "t") begin
            bn.r[0] = '{K_BYTE, (b == "n") ? 8'd10 : 8'd9, 4'd0, 1'b0}; bn.n = 3'd1;
            if (qlen < 2'd2) qlen_next = qlen + 2'd1;
            mode_next = M_QUOTE;
          end else begin
            bn.r[0] = '{K_ERR, b, 4'd0, 1'b0}; bn.n = 3'd1;
            held_next = H_NONE; err_next = 1'b1;
            if (b == 8'd0) begin
              bn.r[1] = '{K_DONE, 8'd0, 4'd0, 1'b0}; bn.n = 3'd2;
              mode_next = M_SKIP; pend_next = '0; qch_next = '0; qlen_next = '0;
              err_next = 1'b0;
            end else if (b == 8'h0a) mode_next = M_SKIP;
            else mode_next = M_ERRSKIP;
          end
        end
        default: begin
          pend_next = '0; held_next = H_NONE; qch_next = '0; qlen_next = '0;
          err_next = 1'b0; rescan = 1'b1;
        end
      endcase
    end

    // fresh scan of b; bursts above leave at most 4 items, so indexes stay in range
    if (rescan) begin
      mode_next = M_SKIP;
      if (b == " " || b == 8'h09 || b == 8'h0a) begin
      end else if (b == 8'd0) begin
        bn.r[bn.n] = '{K_DONE, 8'd0, 4'd0, !err_next}; bn.n = bn.n + 3'd1;
        pend_next = '0; held_next = H_NONE; qch_next = '0; qlen_next = '0;
        err_next = 1'b0;
      end else if (b == "/") held_next = H_SLASH;
      else if (b == "0") mode_next = M_ZERO;
      else if (is_dig(b) || is_alpha(b)) begin
        bn.r[bn.n] = '{K_BYTE, b, 4'd0, 1'b0}; bn.n = bn.n + 3'd1;
        pend_next = is_dig(b) ? C_INT : C_IDENT; mode_next = M_RUN;
      end else if (b == 8'h27 || b == 8'h22) begin
        qch_next = b; qlen_next = '0; mode_next = M_QUOTE;
      end else if (b == "+" || b == "-" || b == "<" || b == ">" || b == "!" || b == "=") begin
        bn.r[bn.n] = '{K_BYTE, b, 4'd0, 1'b0}; bn.n = bn.n + 3'd1; mode_next = M_OPEQ;
      end else if (b == "*") begin
        bn.r[bn.n] = '{K_BYTE, b, 4'd0, 1'b0}; bn.n = bn.n + 3'd1; mode_next = M_STAR;
      end else if (b == "#" || b == "@" || b == "(" || b == ")" || b == "[" || b == "]" ||
                   b == "{" || b == "}" || b == "," || b == "." || b == ":" || b == ";") begin
        bn.r[bn.n] = '{K_BYTE, b, 4'd0, 1'b0};
        bn.r[bn.n + 3'd1] = '{K_END, 8'd0, C_SYM, 1'b0};
        bn.n = bn.n + 3'd2;
      end else begin
        bn.r[bn.n] = '{K_ERR, b, 4'd0, 1'b0}; bn.n = bn.n + 3'd1;
        err_next = 1'b1; held_next = H_NONE; mode_next = M_ERRSKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_SKIP; pend <= '0; held <= H_NONE; qch <= '0; qlen <= '0; err <= 1'b0;
    end else if (in_valid && in_ready) begin
      mode <= mode_next; pend <= pend_next; held <= held_next;
      qch <= qch_next; qlen <= qlen_next; err <= err_next;
    end
  end

endmodule

// ===== hdl/stt_queue.sv =====
// two-entry burst queue between front and back
// depends on stt_pkg
module stt_queue import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t wdata,
  output logic   full,
  output logic   empty,
  input  logic   pop,
  output burst_t rdata
);

  burst_t     mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/stt_back.sv =====
// back end: walks a burst one result per cycle, while the output is not stalled, into the output register
// depends on stt_pkg
module stt_back import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  burst_t     q_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res,
  output logic       out_last
);

  logic [CntW-1:0] idx;
  logic            load;

  assign load = !q_empty && (!out_valid || out_ready);
  assign pop = load && (idx + 3'd1 == q_data.n);

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= q_data.r[idx];
      out_last <= idx + 3'd1 == q_data.n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; idx <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) idx <= '0;
      else if (load) idx <= idx + 3'd1;
    end
  end

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// tokenizer top level: front scanner, burst queue, result sequencer
// depends on stt_pkg, stt_if, stt_front, stt_queue, stt_back
// throughput: one byte per cycle while each byte yields at most one result and the output is not stalled;
// a byte yielding n results holds the output for n output register loads, one result per load
// path: a result is registered into a queue entry, then into the output register
// reset: synchronous rst returns scanner to skip whitespace and empties queue
module source_text_tokenizer import stt_pkg::*; (
  input logic clk,
  input logic rst,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);

  logic   push, full, empty, pop, last;
  burst_t wb, rb;
  res_t   res;

  stt_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.text_byte),
    .push, .burst(wb), .q_full(full)
  );

  stt_queue u_queue (
    .clk, .rst, .push, .wdata(wb), .full, .empty, .pop, .rdata(rb)
  );

  stt_back u_back (
    .clk, .rst, .q_empty(empty), .q_data(rb), .pop, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_res(res), .out_last(last)
  );

  assign out_ch.item_kind = res.kind;
  assign out_ch.byte_value = res.val;
  assign out_ch.token_class = res.cls;
  assign out_ch.text_ok = res.ok;
  assign out_ch.last_of_run = last;

endmodule

// ===== hdl/stt_checker.sv =====
// port-level checks for the tokenizer
// depends on stt_pkg, bound to source_text_tokenizer
module stt_checker import stt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_kind,
  input logic [7:0] byte_value,
  input logic [3:0] token_class,
  input logic       text_ok,
  input logic       last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value))
    else $error("output not held under stall");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == K_DONE |-> last_of_run)
    else $error("done item not last");
  a_cls: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind != K_END |-> token_class == 4'd0)
    else $error("class on non-end item");
  a_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind != K_DONE |-> !text_ok)
    else $error("ok on non-done item");

endmodule

bind source_text_tokenizer stt_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .item_kind(out_ch.item_kind), .byte_value(out_ch.byte_value),
  .token_class(out_ch.token_class), .text_ok(out_ch.text_ok),
  .last_of_run(out_ch.last_of_run)
);
